FILE: rtl/core/s64alu_pkg.sv
// Shared types and constants for the signed integer ALU.
// Used by the top level, front end and back end under rtl/core; depends on nothing.
package s64alu_pkg;

  localparam int FUNC_BITS = 5;
  localparam int FIELD_BITS = 64;

  // Operation codes as carried on the request, plus an internal no-op
  typedef enum logic [FUNC_BITS-1:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_DIV  = 5'd3,
    OP_MOD  = 5'd4,
    OP_SHL  = 5'd5,
    OP_SHR  = 5'd6,
    OP_INC  = 5'd7,
    OP_DEC  = 5'd8,
    OP_NEG  = 5'd9,
    OP_AND  = 5'd10,
    OP_OR   = 5'd11,
    OP_NOT  = 5'd12,
    OP_LAND = 5'd13,
    OP_LOR  = 5'd14,
    OP_LNOT = 5'd15,
    OP_GT   = 5'd16,
    OP_LT   = 5'd17,
    OP_EQ   = 5'd18,
    OP_NE   = 5'd19,
    OP_GE   = 5'd20,
    OP_LE   = 5'd21,
    OP_NOP  = 5'd22
  } op_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0]         func;
    logic signed [FIELD_BITS-1:0] operand_a;
    logic signed [FIELD_BITS-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] value;
    logic                         status;
  } rsp_t;

endpackage

FILE: rtl/core/signed_int64_alu_core.sv
// Signed integer ALU top level: front-end decode, two-entry queue, back end.
// Depends on s64alu_pkg, s64alu_front, s64alu_queue, s64alu_back.
//
// A transaction is taken when start is high and busy is low; each one
// yields exactly one result, shown for one cycle with done high, in order.
// The receiver cannot stall. Non-divide operations flow one per cycle while
// no divide is running or handing over its result; each passes the queue,
// the stage-one register and the result register before done rises.
// Divide and remainder with a nonzero divisor go through the shared
// bit-serial divider, which holds the back end until its result is handed
// over. Later transactions wait in the two-entry queue; busy rises when
// that queue is full. Multiply is split into half-width partial products
// summed in the result stage.
module signed_int64_alu_core #(
  parameter int DATA_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  s64alu_pkg::req_t  req,
  output logic              busy,
  output logic              done,
  output s64alu_pkg::rsp_t  rsp
);
  import s64alu_pkg::*;

  localparam int EW = FUNC_BITS + 2 * DATA_WIDTH + 1;

  logic          push;
  logic          pop;
  logic          q_valid;
  logic          q_full;
  logic [EW-1:0] w_entry;
  logic [EW-1:0] r_entry;

  assign busy = q_full;

  s64alu_front #(.W(DATA_WIDTH)) u_front (
    .start (start),
    .full  (q_full),
    .req   (req),
    .push  (push),
    .entry (w_entry)
  );

  s64alu_queue #(.EW(EW)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (w_entry),
    .pop   (pop),
    .valid (q_valid),
    .full  (q_full),
    .rdata (r_entry)
  );

  s64alu_back #(.W(DATA_WIDTH)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (r_entry),
    .pop     (pop),
    .done    (done),
    .rsp     (rsp)
  );

endmodule

FILE: rtl/core/s64alu_front.sv
// Front end: decodes a request into an operation and a divide-by-zero flag.
// Depends on s64alu_pkg; feeds s64alu_queue.
module s64alu_front #(
  parameter int W = 64
) (
  input  logic              start,
  input  logic              full,
  input  s64alu_pkg::req_t  req,
  output logic              push,
  output logic [s64alu_pkg::FUNC_BITS+2*W:0] entry
);
  import s64alu_pkg::*;

  op_t          op;
  logic [W-1:0] a;
  logic [W-1:0] b;
  logic         dz;

  // Take the transaction when there is room
  assign push = start && !full;

  // Decode the code; unused codes become a no-op
  always_comb begin
    if (req.func <= FUNC_BITS'(OP_LE)) begin
      op = op_t'(req.func);
    end else begin
      op = OP_NOP;
    end
  end

  assign a  = req.operand_a[W-1:0];
  assign b  = req.operand_b[W-1:0];
  assign dz = (op == OP_DIV || op == OP_MOD) && (b == '0);

  assign entry = {op, dz, a, b};

endmodule

FILE: rtl/core/s64alu_queue.sv
// Two-entry queue between the front end and the execution back end.
// Generic data width; no package dependency.
module s64alu_queue #(
  parameter int EW = 134
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [EW-1:0] wdata,
  input  logic          pop,
  output logic          valid,
  output logic          full,
  output logic [EW-1:0] rdata
);
  logic [EW-1:0] mem [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;

  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign rdata = mem[rptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/core/s64alu_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// No package dependency; used by s64alu_back.
module s64alu_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         is_mod,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] result
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  quo;
  logic [W-1:0]  rem;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          neg;
  logic          want_rem;
  logic [W:0]    trial;
  logic [W-1:0]  mag_a;
  logic [W-1:0]  mag_b;
  logic [W-1:0]  pick;

  assign mag_a = a[W-1] ? (~a + W'(1)) : a;
  assign mag_b = b[W-1] ? (~b + W'(1)) : b;
  assign trial = {rem, quo[W-1]} - {1'b0, dvs};

  // Apply the sign to the finished quotient or remainder
  assign pick   = want_rem ? rem : quo;
  assign result = neg ? (~pick + W'(1)) : pick;

  // Hold operands and step one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo      <= mag_a;
      rem      <= '0;
      dvs      <= mag_b;
      want_rem <= is_mod;
      neg      <= is_mod ? a[W-1] : (a[W-1] ^ b[W-1]);
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  // Count iterations and flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/core/s64alu_back.sv
// Back end: executes queued operations in order through two register stages.
// Depends on s64alu_pkg and s64alu_div.
module s64alu_back #(
  parameter int W = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_valid,
  input  logic [s64alu_pkg::FUNC_BITS+2*W:0]  q_entry,
  output logic                                 pop,
  output logic                                 done,
  output s64alu_pkg::rsp_t                     rsp
);
  import s64alu_pkg::*;

  localparam int LO = (W + 1) / 2;
  localparam int HI = W - LO;

  op_t               op;
  logic              dz;
  logic [W-1:0]      a;
  logic [W-1:0]      b;
  logic [5:0]        sh;
  logic              is_div;
  logic              div_busy;
  logic              div_done;
  logic [W-1:0]      div_res;
  logic [W-1:0]      plain;
  logic              plain_st;
  logic [2*LO-1:0]   m0;
  logic [HI-1:0]     m1;
  logic [HI-1:0]     m2;

  // First stage registers
  logic              e1_valid;
  logic              e1_mul;
  logic [W-1:0]      e1_val;
  logic              e1_st;
  logic [2*LO-1:0]   e1_p0;
  logic [HI-1:0]     e1_p1;
  logic [HI-1:0]     e1_p2;
  logic [HI-1:0]     p_sum;
  logic [W-1:0]      e1_out;

  assign op = op_t'(q_entry[FUNC_BITS+2*W -: FUNC_BITS]);
  assign dz = q_entry[2*W];
  assign a  = q_entry[2*W-1:W];
  assign b  = q_entry[W-1:0];
  assign sh = b[5:0];

  assign is_div = (op == OP_DIV || op == OP_MOD) && !dz;
  // Hold the queue while a divide runs or hands its result over
  assign pop    = q_valid && !div_busy && !div_done;

  s64alu_div #(.W(W)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (pop && is_div),
    .is_mod (op == OP_MOD),
    .a      (a),
    .b      (b),
    .busy   (div_busy),
    .done   (div_done),
    .result (div_res)
  );

  // Combinational operations
  always_comb begin
    plain    = '0;
    plain_st = 1'b0;
    unique case (op)
      OP_ADD:  plain = a + b;
      OP_SUB:  plain = a - b;
      OP_SHL:  plain = a << sh;
      OP_SHR:  plain = $signed(a) >>> sh;
      OP_INC:  plain = a + W'(1);
      OP_DEC:  plain = a - W'(1);
      OP_NEG:  plain = ~a + W'(1);
      OP_AND:  plain = a & b;
      OP_OR:   plain = a | b;
      OP_NOT:  plain = ~a;
      OP_LAND: plain = W'((a != '0) && (b != '0));
      OP_LOR:  plain = W'((a != '0) || (b != '0));
      OP_LNOT: plain = W'(a == '0);
      OP_GT:   plain = W'($signed(a) > $signed(b));
      OP_LT:   plain = W'($signed(a) < $signed(b));
      OP_EQ:   plain = W'(a == b);
      OP_NE:   plain = W'(a != b);
      OP_GE:   plain = W'($signed(a) >= $signed(b));
      OP_LE:   plain = W'($signed(a) <= $signed(b));
      OP_DIV, OP_MOD: plain_st = dz;
      default: plain = '0;
    endcase
  end

  // Partial products of the low word of a * b
  assign m0 = (2*LO)'(a[LO-1:0]) * (2*LO)'(b[LO-1:0]);
  assign m1 = a[HI-1:0] * b[W-1:LO];
  assign m2 = a[W-1:LO] * b[HI-1:0];

  // Stage one: register simple results, divider output or partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
    end else begin
      e1_valid <= (pop && !is_div) || div_done;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      e1_mul <= 1'b0;
      e1_val <= div_res;
      e1_st  <= 1'b0;
    end else begin
      e1_mul <= (op == OP_MUL);
      e1_val <= plain;
      e1_st  <= plain_st;
    end
    e1_p0 <= m0;
    e1_p1 <= m1;
    e1_p2 <= m2;
  end

  // Combine cross products into the upper half of the product
  assign p_sum  = e1_p1 + e1_p2;
  assign e1_out = e1_mul ? (e1_p0[W-1:0] + {p_sum, {LO{1'b0}}}) : e1_val;

  // Stage two: result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= e1_valid;
    end
  end

  always_ff @(posedge clk) begin
    rsp.value  <= FIELD_BITS'($signed(e1_out));
    rsp.status <= e1_st;
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for signed_int64_alu_core: directed and random operations.
// Depends on s64alu_pkg and the signed_int64_alu_core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import s64alu_pkg::*;

  localparam longint MINV = 64'sh8000000000000000;
  localparam longint MAXV = 64'sh7fffffffffffffff;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic start;
  req_t req;
  logic busy;
  logic done;
  rsp_t rsp;

  rsp_t expected_rsp_q[$];
  int   error_count = 0;
  int   cycle_count = 0;

  signed_int64_alu_core #(.DATA_WIDTH(64)) u_dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .done(done), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Compute the expected result of one operation
  function automatic rsp_t alu_predict(req_t r);
    rsp_t o;
    logic signed [63:0] a, b;
    logic [63:0] ma, mb, q;
    logic [5:0] sh;
    a = r.operand_a;
    b = r.operand_b;
    sh = b[5:0];
    o.value = '0;
    o.status = 1'b0;
    case (r.func)
      OP_ADD:  o.value = a + b;
      OP_SUB:  o.value = a - b;
      OP_MUL:  o.value = a * b;
      OP_DIV, OP_MOD: begin
        if (b == 0) begin
          o.status = 1'b1;
        end else begin
          ma = a[63] ? -a : a;
          mb = b[63] ? -b : b;
          if (r.func == OP_DIV) begin
            q = ma / mb;
            o.value = (a[63] != b[63]) ? -q : q;
          end else begin
            q = ma % mb;
            o.value = a[63] ? -q : q;
          end
        end
      end
      OP_SHL:  o.value = a << sh;
      OP_SHR:  o.value = a >>> sh;
      OP_INC:  o.value = a + 1;
      OP_DEC:  o.value = a - 1;
      OP_NEG:  o.value = -a;
      OP_AND:  o.value = a & b;
      OP_OR:   o.value = a | b;
      OP_NOT:  o.value = ~a;
      OP_LAND: o.value = {63'd0, (a != 0) && (b != 0)};
      OP_LOR:  o.value = {63'd0, (a != 0) || (b != 0)};
      OP_LNOT: o.value = {63'd0, a == 0};
      OP_GT:   o.value = {63'd0, a > b};
      OP_LT:   o.value = {63'd0, a < b};
      OP_EQ:   o.value = {63'd0, a == b};
      OP_NE:   o.value = {63'd0, a != b};
      OP_GE:   o.value = {63'd0, a >= b};
      OP_LE:   o.value = {63'd0, a <= b};
      default: o.value = '0;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("mismatch: %s", what);
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    rsp_t exp_rsp;
    cycle_count <= cycle_count + 1;
    if (!rst && done) begin
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("result with no transaction outstanding");
      end else begin
        exp_rsp = expected_rsp_q.pop_front();
        if (rsp.value !== exp_rsp.value)
          report_mismatch($sformatf("value got %h exp %h", rsp.value, exp_rsp.value));
        if (rsp.status !== exp_rsp.status)
          report_mismatch($sformatf("status got %b exp %b", rsp.status, exp_rsp.status));
      end
    end
  end

  // Abort on runaway simulation
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[signed_int64_alu_core] ERROR");
      $finish;
    end
  end

  // Send one transaction and hold until accepted
  task automatic send_op(logic [4:0] f, logic [63:0] a, logic [63:0] b);
    req_t r;
    r.func = f;
    r.operand_a = a;
    r.operand_b = b;
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    expected_rsp_q.push_back(alu_predict(r));
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: v = MINV;
      1: v = MAXV;
      2: v = '0;
      3: v = '1;
      4: v = 64'(longint'($urandom_range(0, 20)) - 64'sd10);
      5: v = v >> $urandom_range(0, 63);
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_directed();
    send_op(OP_ADD, MAXV, 1);
    send_op(OP_SUB, MINV, 1);
    send_op(OP_MUL, MINV, -1);
    send_op(OP_DIV, MINV, -1);
    send_op(OP_MOD, MINV, -1);
    send_op(OP_DIV, 7, 0);
    send_op(OP_MOD, -7, 0);
    send_op(OP_DIV, -7, 2);
    send_op(OP_MOD, -7, 2);
    send_op(OP_MOD, 7, -2);
    send_op(OP_SHL, -1, 63);
    send_op(OP_SHR, MINV, 63);
    send_op(OP_SHR, MINV, 64'hffffffffffffffc1);
    send_op(OP_INC, MAXV, 5);
    send_op(OP_DEC, MINV, 5);
    send_op(OP_NEG, MINV, 0);
    send_op(OP_AND, MINV, -1);
    send_op(OP_OR, 0, MAXV);
    send_op(OP_NOT, 0, 3);
    send_op(OP_LAND, MINV, 0);
    send_op(OP_LOR, 0, 0);
    send_op(OP_LNOT, 0, 9);
    send_op(OP_GT, MINV, MAXV);
    send_op(OP_LE, MAXV, MAXV);
    send_op(5'd31, MAXV, MAXV);
    drain();
  endtask

  // Random ops in bursts, including the unused codes and back-to-back divides
  task automatic test_random(int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        send_op(5'($urandom_range(0, 9) == 0 ? $urandom_range(22, 31)
                                             : $urandom_range(0, 21)),
                rand64(), rand64());
        sent++;
      end
      if (sent > count / 2 && sent - burst <= count / 2) drain();
      else if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(550);
    if (error_count == 0) $display("[signed_int64_alu_core] OK");
    else $display("[signed_int64_alu_core] ERROR");
    $finish;
  end
endmodule
